// File: rtl/core/line_sensor_position_estimator_assert.svh
// Assertion macros used by the top-level RTL.
`ifndef LINE_SENSOR_POSITION_ESTIMATOR_ASSERT_SVH
`define LINE_SENSOR_POSITION_ESTIMATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LSPE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define LSPE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/ls_pkg.sv
`default_nettype none
package ls_pkg;

	localparam int SENSOR_COUNT = 6;
	localparam int CH_W         = 3;
	localparam int LEVEL_W      = 8;
	localparam int POS_W        = 10;
	localparam int COUNT_W      = 3;
	localparam int LSUM_W       = 11;
	localparam int WEIGHT_W     = 10;
	localparam int WPROD_W      = 18;
	localparam int WSUM_W       = 19;
	localparam int QUO_W        = 10;
	localparam int QBITS_W      = 4;
	localparam int RECIP_W      = 16;
	localparam int RECIP_SHIFT  = 19;

	localparam logic [QBITS_W-1:0]  LEVEL_QBITS = 4'd8;
	localparam logic [QBITS_W-1:0]  POS_QBITS   = 4'd10;
	localparam logic [RECIP_W-1:0]  RECIP10     = 16'd52429;

	localparam logic [POS_W-1:0]    POS_CENTRE      = 10'd350;
	localparam logic [POS_W-1:0]    POS_LEFT_LIMIT  = 10'd250;
	localparam logic [POS_W-1:0]    POS_RIGHT_LIMIT = 10'd450;
	localparam logic [POS_W-1:0]    POS_LOST_LEFT   = 10'd90;
	localparam logic [POS_W-1:0]    POS_LOST_RIGHT  = POS_W'(SENSOR_COUNT * 100 + 10);
	localparam logic [WEIGHT_W-1:0] POS_STEP        = 10'd100;

	typedef struct packed {
		logic                start;
		logic [QBITS_W-1:0]  qbits;
	} div_ctl_t;

	typedef struct packed {
		logic clear;
		logic fold;
		logic rd;
	} cal_ctl_t;

endpackage
`default_nettype wire

// File: rtl/core/ls_cal.sv
`default_nettype none
module ls_cal #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ls_pkg::cal_ctl_t             ctl,
	input  logic [ls_pkg::CH_W-1:0]      rd_idx,
	input  logic [SAMPLE_BITS-1:0]       samples [ls_pkg::SENSOR_COUNT],
	output logic [SAMPLE_BITS-1:0]       lo,
	output logic [SAMPLE_BITS-1:0]       hi
);

	logic [SAMPLE_BITS-1:0] min_q [ls_pkg::SENSOR_COUNT];
	logic [SAMPLE_BITS-1:0] max_q [ls_pkg::SENSOR_COUNT];
	logic [SAMPLE_BITS-1:0] lo_q;
	logic [SAMPLE_BITS-1:0] hi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ls_pkg::SENSOR_COUNT; i++) begin
				min_q[i] <= '1;
				max_q[i] <= '0;
			end
		end else if (ctl.clear) begin
			for (int i = 0; i < ls_pkg::SENSOR_COUNT; i++) begin
				min_q[i] <= '1;
				max_q[i] <= '0;
			end
		end else if (ctl.fold) begin
			for (int i = 0; i < ls_pkg::SENSOR_COUNT; i++) begin
				if (samples[i] < min_q[i])
					min_q[i] <= samples[i];
				if (samples[i] > max_q[i])
					max_q[i] <= samples[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd) begin
			lo_q <= min_q[rd_idx];
			hi_q <= max_q[rd_idx];
		end
	end

	assign lo = lo_q;
	assign hi = hi_q;

endmodule
`default_nettype wire

// File: rtl/core/ls_div.sv
`default_nettype none
module ls_div #(
	parameter int NUM_W = 20,
	parameter int DEN_W = 12
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ls_pkg::div_ctl_t          ctl,
	input  logic [NUM_W-1:0]          num,
	input  logic [DEN_W-1:0]          den,
	output logic                      done,
	output logic [ls_pkg::QUO_W-1:0]  quo
);

	localparam int QW = ls_pkg::QUO_W;

	logic [DEN_W-1:0]             rem_q;
	logic [DEN_W-1:0]             den_q;
	logic [QW-1:0]                low_q;
	logic [QW-1:0]                quo_q;
	logic [ls_pkg::QBITS_W-1:0]   cnt_q;
	logic                         busy_q;
	logic                         done_q;
	logic [DEN_W:0]               trial;
	logic [DEN_W:0]               trial_sub;
	logic                         ge;

	assign trial     = {rem_q, low_q[QW-1]};
	assign trial_sub = trial - {1'b0, den_q};
	assign ge        = trial >= {1'b0, den_q};

	// one quotient bit per cycle, msb first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ctl.qbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == ls_pkg::QBITS_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= DEN_W'(num >> ctl.qbits);
			low_q <= num[QW-1:0] << (ls_pkg::QBITS_W'(QW) - ctl.qbits);
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
			low_q <= {low_q[QW-2:0], 1'b0};
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule
`default_nettype wire

// File: rtl/core/line_sensor_position_estimator.sv
// Measure frames: in_stall holds off the next frame until the result is loaded for output.
// Per channel: the shared bit-serial divider runs when the range is valid (8 quotient bits).
// Position: divider (10 quotient bits) for 1 or 2 line channels; clear/calibrate never stall.
// Reset: calibration min all ones, max zero, previous position 350, noise 10, line level 25.
`default_nettype none
`include "line_sensor_position_estimator_assert.svh"
module line_sensor_position_estimator #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [1:0]             action,
	input  logic [SAMPLE_BITS-1:0] sample_0,
	input  logic [SAMPLE_BITS-1:0] sample_1,
	input  logic [SAMPLE_BITS-1:0] sample_2,
	input  logic [SAMPLE_BITS-1:0] sample_3,
	input  logic [SAMPLE_BITS-1:0] sample_4,
	input  logic [SAMPLE_BITS-1:0] sample_5,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [9:0]             position,
	output logic [5:0]             line_bits,
	output logic [2:0]             line_count,
	output logic [7:0]             level_0,
	output logic [7:0]             level_1,
	output logic [7:0]             level_2,
	output logic [7:0]             level_3,
	output logic [7:0]             level_4,
	output logic [7:0]             level_5,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic                   cfg_index,
	input  logic [7:0]             cfg_data
);

	localparam int CH      = ls_pkg::SENSOR_COUNT;
	localparam int NUM10_W = SAMPLE_BITS + 4;
	localparam int NUM_W   = (NUM10_W > ls_pkg::WSUM_W) ? NUM10_W : ls_pkg::WSUM_W;
	localparam int DEN_W   = (SAMPLE_BITS > ls_pkg::LSUM_W) ? SAMPLE_BITS : ls_pkg::LSUM_W;
	localparam int RPROD_W = SAMPLE_BITS + ls_pkg::RECIP_W;

	localparam logic [1:0] ACT_CLEAR   = 2'd0;
	localparam logic [1:0] ACT_CAL     = 2'd1;
	localparam logic [1:0] ACT_MEASURE = 2'd2;

	localparam logic CFG_NOISE_FLOOR = 1'b0;
	localparam logic CFG_LINE_LEVEL  = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_RANGE, S_RECIP, S_START, S_DIVW,
		S_ACC, S_ACC2, S_POS, S_PDIV, S_DONE
	} state_t;

	state_t                           state_q;
	logic [ls_pkg::CH_W-1:0]          ch_q;
	logic                             out_valid_q;
	logic [ls_pkg::POS_W-1:0]         position_q;
	logic [CH-1:0]                    line_bits_q;
	logic [ls_pkg::COUNT_W-1:0]       line_count_q;
	logic [ls_pkg::LEVEL_W-1:0]       lvl_out_q [CH];
	logic [ls_pkg::POS_W-1:0]         prev_pos_q;
	logic [7:0]                       noise_floor_q;
	logic [7:0]                       line_level_q;

	logic [SAMPLE_BITS-1:0]           smp_q [CH];
	logic                             inv_q;
	logic [SAMPLE_BITS-1:0]           diff_q;
	logic [SAMPLE_BITS-1:0]           num_q;
	logic [DEN_W-1:0]                 den_q;
	logic [NUM10_W-1:0]               num10_q;
	logic [ls_pkg::LEVEL_W-1:0]       lv_q;
	logic [ls_pkg::WPROD_W-1:0]       prod_q;
	logic [ls_pkg::WEIGHT_W-1:0]      weight_q;
	logic [ls_pkg::LSUM_W-1:0]        sum_q;
	logic [ls_pkg::WSUM_W-1:0]        wsum_q;
	logic [CH-1:0]                    bits_q;
	logic [ls_pkg::COUNT_W-1:0]       cnt_q;
	logic [ls_pkg::LEVEL_W-1:0]       lvl_q [CH];
	logic [ls_pkg::POS_W-1:0]         pos_q;

	logic [SAMPLE_BITS-1:0]           sample_in [CH];
	logic                             accept_in;
	logic                             out_free;
	ls_pkg::cal_ctl_t                 cal_ctl;
	logic [SAMPLE_BITS-1:0]           cal_lo;
	logic [SAMPLE_BITS-1:0]           cal_hi;
	logic [SAMPLE_BITS-1:0]           cur;
	logic [SAMPLE_BITS-1:0]           vc;
	logic [RPROD_W-1:0]               rprod;
	logic                             skip;
	logic                             pos_div;
	logic [ls_pkg::POS_W-1:0]         lost_pos;
	ls_pkg::div_ctl_t                 div_ctl;
	logic [NUM_W-1:0]                 div_num;
	logic [DEN_W-1:0]                 div_den;
	logic                             div_done;
	logic [ls_pkg::QUO_W-1:0]         div_quo;
	logic [ls_pkg::LEVEL_W-1:0]       q_lv;
	logic [ls_pkg::LEVEL_W-1:0]       lv_next;
	logic                             on_line;

	assign sample_in[0] = sample_0;
	assign sample_in[1] = sample_1;
	assign sample_in[2] = sample_2;
	assign sample_in[3] = sample_3;
	assign sample_in[4] = sample_4;
	assign sample_in[5] = sample_5;

	assign in_stall  = (state_q != S_IDLE);
	assign accept_in = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	assign cal_ctl.clear = accept_in && (action == ACT_CLEAR);
	assign cal_ctl.fold  = accept_in && (action == ACT_CAL);
	assign cal_ctl.rd    = (state_q == S_RD);

	ls_cal #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_cal (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (cal_ctl),
		.rd_idx  (ch_q),
		.samples (sample_in),
		.lo      (cal_lo),
		.hi      (cal_hi)
	);

	assign cur = smp_q[0];

	always_comb begin
		if (cur < cal_lo)
			vc = cal_lo;
		else if (cur > cal_hi)
			vc = cal_hi;
		else
			vc = cur;
	end

	// range / 10 by reciprocal, exact below 81920
	assign rprod = RPROD_W'(diff_q) * RPROD_W'(ls_pkg::RECIP10);

	assign skip    = inv_q || (den_q == '0);
	assign pos_div = (cnt_q != '0) && (cnt_q <= ls_pkg::COUNT_W'(2)) && (sum_q != '0);

	always_comb begin
		if (prev_pos_q < ls_pkg::POS_LEFT_LIMIT)
			lost_pos = ls_pkg::POS_LOST_LEFT;
		else if (prev_pos_q > ls_pkg::POS_RIGHT_LIMIT)
			lost_pos = ls_pkg::POS_LOST_RIGHT;
		else
			lost_pos = ls_pkg::POS_CENTRE;
	end

	assign div_ctl.start = ((state_q == S_START) && !skip) || ((state_q == S_POS) && pos_div);
	assign div_ctl.qbits = (state_q == S_POS) ? ls_pkg::POS_QBITS : ls_pkg::LEVEL_QBITS;
	assign div_num = (state_q == S_POS) ? NUM_W'(wsum_q) : NUM_W'(num10_q);
	assign div_den = (state_q == S_POS) ? DEN_W'(sum_q) : den_q;

	ls_div #(
		.NUM_W (NUM_W),
		.DEN_W (DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign q_lv    = div_quo[ls_pkg::LEVEL_W-1:0];
	assign lv_next = (q_lv < noise_floor_q) ? '0 : q_lv;
	assign on_line = lv_q > line_level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_floor_q <= 8'd10;
			line_level_q  <= 8'd25;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_NOISE_FLOOR: noise_floor_q <= cfg_data;
				CFG_LINE_LEVEL:  line_level_q  <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			ch_q         <= '0;
			out_valid_q  <= 1'b0;
			position_q   <= '0;
			line_bits_q  <= '0;
			line_count_q <= '0;
			prev_pos_q   <= ls_pkg::POS_CENTRE;
			for (int i = 0; i < CH; i++)
				lvl_out_q[i] <= '0;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept_in && (action == ACT_MEASURE)) begin
						state_q <= S_RD;
						ch_q    <= '0;
					end
				end
				S_RD:    state_q <= S_RANGE;
				S_RANGE: state_q <= S_RECIP;
				S_RECIP: state_q <= S_START;
				S_START: state_q <= skip ? S_ACC : S_DIVW;
				S_DIVW: begin
					if (div_done)
						state_q <= S_ACC;
				end
				S_ACC:   state_q <= S_ACC2;
				S_ACC2: begin
					ch_q <= ch_q + 1'b1;
					if (ch_q == ls_pkg::CH_W'(CH - 1))
						state_q <= S_POS;
					else
						state_q <= S_RD;
				end
				S_POS:   state_q <= pos_div ? S_PDIV : S_DONE;
				S_PDIV: begin
					if (div_done)
						state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q      <= S_IDLE;
						out_valid_q  <= 1'b1;
						position_q   <= pos_q;
						prev_pos_q   <= pos_q;
						line_bits_q  <= bits_q;
						line_count_q <= cnt_q;
						for (int i = 0; i < CH; i++)
							lvl_out_q[i] <= lvl_q[i];
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// channel and position datapath: samples and levels shift one channel per step
	always_ff @(posedge clk) begin
		if (accept_in && (action == ACT_MEASURE)) begin
			smp_q    <= sample_in;
			sum_q    <= '0;
			wsum_q   <= '0;
			bits_q   <= '0;
			cnt_q    <= '0;
			weight_q <= ls_pkg::POS_STEP;
		end
		if (state_q == S_RANGE) begin
			inv_q  <= cal_hi < cal_lo;
			diff_q <= cal_hi - cal_lo;
			num_q  <= vc - cal_lo;
		end
		if (state_q == S_RECIP) begin
			den_q   <= DEN_W'(rprod >> ls_pkg::RECIP_SHIFT);
			num10_q <= (NUM10_W'(num_q) << 3) + (NUM10_W'(num_q) << 1);
		end
		if ((state_q == S_START) && skip)
			lv_q <= '0;
		if ((state_q == S_DIVW) && div_done)
			lv_q <= lv_next;
		if (state_q == S_ACC) begin
			prod_q <= ls_pkg::WPROD_W'(lv_q) * ls_pkg::WPROD_W'(weight_q);
			sum_q  <= sum_q + ls_pkg::LSUM_W'(lv_q);
			bits_q <= {bits_q[CH-2:0], on_line};
			if (on_line)
				cnt_q <= cnt_q + 1'b1;
			for (int i = 0; i < CH - 1; i++)
				lvl_q[i] <= lvl_q[i+1];
			lvl_q[CH-1] <= lv_q;
		end
		if (state_q == S_ACC2) begin
			wsum_q   <= wsum_q + ls_pkg::WSUM_W'(prod_q);
			weight_q <= weight_q + ls_pkg::POS_STEP;
			for (int i = 0; i < CH - 1; i++)
				smp_q[i] <= smp_q[i+1];
		end
		if ((state_q == S_POS) && !pos_div)
			pos_q <= (cnt_q == '0) ? lost_pos : ls_pkg::POS_CENTRE;
		if ((state_q == S_PDIV) && div_done)
			pos_q <= div_quo[ls_pkg::POS_W-1:0];
	end

	assign out_valid  = out_valid_q;
	assign position   = position_q;
	assign line_bits  = line_bits_q;
	assign line_count = line_count_q;
	assign level_0    = lvl_out_q[0];
	assign level_1    = lvl_out_q[1];
	assign level_2    = lvl_out_q[2];
	assign level_3    = lvl_out_q[3];
	assign level_4    = lvl_out_q[4];
	assign level_5    = lvl_out_q[5];

	`LSPE_ASSERT_NOW(a_count_bits, out_valid, $countones(line_bits) == line_count, "line count disagrees with line bits")
	`LSPE_ASSERT_NOW(a_crowd_centre, out_valid && (line_count > 3'd2), position == ls_pkg::POS_CENTRE, "crowded line not centred")
	`LSPE_ASSERT_NOW(a_div_owner, div_done, (state_q == S_DIVW) || (state_q == S_PDIV), "divider finished with no waiting step")
	`LSPE_ASSERT_NEXT(a_result_load, (state_q == S_DONE) && out_free, out_valid && (position == $past(pos_q)), "result not loaded")

endmodule
`default_nettype wire

// File: tb/lspe_tb_pkg.sv
package lspe_tb_pkg;

	localparam int SAMPLE_W = 12;

	typedef enum logic [1:0] {
		ACT_CLEAR     = 2'd0,
		ACT_CALIBRATE = 2'd1,
		ACT_MEASURE   = 2'd2,
		ACT_UNUSED    = 2'd3
	} action_e;

	localparam logic REG_NOISE_FLOOR = 1'b0;
	localparam logic REG_LINE_LEVEL  = 1'b1;

endpackage

// File: tb/line_estimate_checker.sv
module line_estimate_checker
	import ls_pkg::*;
	import lspe_tb_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic [1:0]          action,
	input  logic [SAMPLE_W-1:0] sample_0,
	input  logic [SAMPLE_W-1:0] sample_1,
	input  logic [SAMPLE_W-1:0] sample_2,
	input  logic [SAMPLE_W-1:0] sample_3,
	input  logic [SAMPLE_W-1:0] sample_4,
	input  logic [SAMPLE_W-1:0] sample_5,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic [9:0]          position,
	input  logic [5:0]          line_bits,
	input  logic [2:0]          line_count,
	input  logic [7:0]          level_0,
	input  logic [7:0]          level_1,
	input  logic [7:0]          level_2,
	input  logic [7:0]          level_3,
	input  logic [7:0]          level_4,
	input  logic [7:0]          level_5,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [7:0]          cfg_data,
	output int                  mismatches,
	output int                  pending
);

	localparam int SCALE       = 10;
	localparam int MAX_REPORTS = 150;

	typedef logic [SENSOR_COUNT-1:0][SAMPLE_W-1:0] frame_t;

	typedef struct packed {
		logic [POS_W-1:0]                        position;
		logic [SENSOR_COUNT-1:0]                 line_bits;
		logic [COUNT_W-1:0]                      line_count;
		logic [SENSOR_COUNT-1:0][LEVEL_W-1:0]    levels;
	} estimate_t;

	int            cal_min [SENSOR_COUNT];
	int            cal_max [SENSOR_COUNT];
	logic [POS_W-1:0] last_pos;
	int            floor_level;
	int            line_thresh;
	estimate_t     expected_estimates [$];

	initial begin
		mismatches = 0;
		pending    = 0;
	end

	function automatic int scaled_level(int ch, int v);
		int lo;
		int hi;
		int divisor;
		int val;
		lo = cal_min[ch];
		hi = cal_max[ch];
		if (hi < lo)
			return 0;
		divisor = (hi - lo) / SCALE;
		if (divisor == 0)
			return 0;
		if (v < lo)
			v = lo;
		if (v > hi)
			v = hi;
		val = (v - lo) * SCALE / divisor;
		if (val < floor_level)
			val = 0;
		return val;
	endfunction

	function automatic estimate_t estimate_frame(frame_t s);
		estimate_t e;
		int lv;
		int sum;
		int weighted;
		int count;
		e        = '0;
		sum      = 0;
		weighted = 0;
		count    = 0;
		for (int i = 0; i < SENSOR_COUNT; i++) begin
			lv          = scaled_level(i, int'(s[i]));
			e.levels[i] = LEVEL_W'(lv);
			sum         += lv;
			weighted    += lv * (i + 1) * int'(POS_STEP);
			if (lv > line_thresh) begin
				count++;
				e.line_bits[SENSOR_COUNT-1-i] = 1'b1;
			end
		end
		e.line_count = COUNT_W'(count);
		if (count == 0) begin
			if (last_pos < POS_LEFT_LIMIT)
				e.position = POS_LOST_LEFT;
			else if (last_pos > POS_RIGHT_LIMIT)
				e.position = POS_LOST_RIGHT;
			else
				e.position = POS_CENTRE;
		end else if (count > 2 || sum == 0) begin
			e.position = POS_CENTRE;
		end else begin
			e.position = POS_W'(weighted / sum);
		end
		return e;
	endfunction

	task automatic check_field(string name, int want_v, int got_v);
		if (want_v != got_v) begin
			if (mismatches < MAX_REPORTS)
				$display("%0t: %s expected %0d actual %0d", $time, name, want_v, got_v);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		estimate_t want;
		frame_t    frame;
		logic [SENSOR_COUNT-1:0][LEVEL_W-1:0] got_levels;
		if (!arst_n) begin
			for (int i = 0; i < SENSOR_COUNT; i++) begin
				cal_min[i] = (1 << SAMPLE_W) - 1;
				cal_max[i] = 0;
			end
			last_pos    = POS_CENTRE;
			floor_level = 10;
			line_thresh = 25;
			expected_estimates.delete();
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_estimates.size() == 0) begin
					if (mismatches < MAX_REPORTS)
						$display("%0t: unexpected result expected none actual position %0d",
							$time, position);
					mismatches++;
				end else begin
					want       = expected_estimates.pop_front();
					got_levels = {level_5, level_4, level_3, level_2, level_1, level_0};
					check_field("position", want.position, position);
					check_field("line_bits", want.line_bits, line_bits);
					check_field("line_count", want.line_count, line_count);
					for (int i = 0; i < SENSOR_COUNT; i++)
						check_field($sformatf("level_%0d", i), want.levels[i], got_levels[i]);
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_NOISE_FLOOR)
					floor_level = cfg_data;
				else
					line_thresh = cfg_data;
			end
			if (in_valid && !in_stall) begin
				frame = {sample_5, sample_4, sample_3, sample_2, sample_1, sample_0};
				case (action_e'(action))
					ACT_CLEAR: begin
						for (int i = 0; i < SENSOR_COUNT; i++) begin
							cal_min[i] = (1 << SAMPLE_W) - 1;
							cal_max[i] = 0;
						end
					end
					ACT_CALIBRATE: begin
						for (int i = 0; i < SENSOR_COUNT; i++) begin
							if (int'(frame[i]) < cal_min[i])
								cal_min[i] = frame[i];
							if (int'(frame[i]) > cal_max[i])
								cal_max[i] = frame[i];
						end
					end
					ACT_MEASURE: begin
						want     = estimate_frame(frame);
						last_pos = want.position;
						expected_estimates.push_back(want);
					end
					default: ;
				endcase
			end
			pending = expected_estimates.size();
		end
	end

endmodule

// File: tb/tb.sv
module tb;
	import ls_pkg::*;
	import lspe_tb_pkg::*;

	localparam int CLK_PERIOD    = 12;
	localparam int SETTLE_CYCLES = 120;
	localparam int RANDOM_ITEMS  = 1050;
	localparam int HOLD_CYCLES   = 400;
	localparam int SAMPLE_MAX    = (1 << SAMPLE_W) - 1;

	typedef logic [SENSOR_COUNT-1:0][SAMPLE_W-1:0] frame_t;

	logic                clk;
	logic                arst_n     = 1'b0;
	logic                in_valid   = 1'b0;
	logic                in_stall;
	logic [1:0]          action     = ACT_CLEAR;
	logic [SAMPLE_W-1:0] sample_0   = '0;
	logic [SAMPLE_W-1:0] sample_1   = '0;
	logic [SAMPLE_W-1:0] sample_2   = '0;
	logic [SAMPLE_W-1:0] sample_3   = '0;
	logic [SAMPLE_W-1:0] sample_4   = '0;
	logic [SAMPLE_W-1:0] sample_5   = '0;
	logic                out_valid;
	logic                out_stall  = 1'b0;
	logic [9:0]          position;
	logic [5:0]          line_bits;
	logic [2:0]          line_count;
	logic [7:0]          level_0;
	logic [7:0]          level_1;
	logic [7:0]          level_2;
	logic [7:0]          level_3;
	logic [7:0]          level_4;
	logic [7:0]          level_5;
	logic                cfg_valid  = 1'b0;
	logic                cfg_ready;
	logic                cfg_index  = REG_NOISE_FLOOR;
	logic [7:0]          cfg_data   = '0;

	int mismatches;
	int pending;
	int idle_pct   = 0;
	int stall_pct  = 0;
	int hold_len   = 0;
	int item_total = 0;

	line_sensor_position_estimator #(
		.SAMPLE_BITS(SAMPLE_W)
	) u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .action(action),
		.sample_0(sample_0), .sample_1(sample_1), .sample_2(sample_2),
		.sample_3(sample_3), .sample_4(sample_4), .sample_5(sample_5),
		.out_valid(out_valid), .out_stall(out_stall),
		.position(position), .line_bits(line_bits), .line_count(line_count),
		.level_0(level_0), .level_1(level_1), .level_2(level_2),
		.level_3(level_3), .level_4(level_4), .level_5(level_5),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	line_estimate_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .action(action),
		.sample_0(sample_0), .sample_1(sample_1), .sample_2(sample_2),
		.sample_3(sample_3), .sample_4(sample_4), .sample_5(sample_5),
		.out_valid(out_valid), .out_stall(out_stall),
		.position(position), .line_bits(line_bits), .line_count(line_count),
		.level_0(level_0), .level_1(level_1), .level_2(level_2),
		.level_3(level_3), .level_4(level_4), .level_5(level_5),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatches(mismatches), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#(CLK_PERIOD * 3_000_000);
		$display("RESULT: ERROR");
		$finish;
	end

	// receiver: random stalls, plus a long hold-off when asked
	initial begin
		forever begin
			@(posedge clk);
			if (hold_len > 0) begin
				out_stall <= 1'b1;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	function automatic frame_t make_frame(int s0, int s1, int s2, int s3, int s4, int s5);
		return {SAMPLE_W'(s5), SAMPLE_W'(s4), SAMPLE_W'(s3),
			SAMPLE_W'(s2), SAMPLE_W'(s1), SAMPLE_W'(s0)};
	endfunction

	function automatic frame_t uniform(int v);
		return make_frame(v, v, v, v, v, v);
	endfunction

	function automatic frame_t random_frame();
		frame_t f;
		for (int i = 0; i < SENSOR_COUNT; i++)
			f[i] = $urandom_range(SAMPLE_MAX);
		return f;
	endfunction

	// frame with a random set of channels near the top of their range, the rest near the bottom, or fully random
	function automatic frame_t line_frame(frame_t lo, frame_t hi);
		frame_t f;
		logic [SENSOR_COUNT-1:0] on;
		int a;
		int b;
		int span;
		int pick;
		pick = $urandom_range(9);
		case (pick)
			0: on = '0;
			1, 2, 3: on = 6'b1 << $urandom_range(5);
			4, 5: on = 6'b11 << $urandom_range(4);
			6: on = (6'b1 << $urandom_range(5)) | (6'b1 << $urandom_range(5));
			default: on = $urandom_range(63);
		endcase
		for (int i = 0; i < SENSOR_COUNT; i++) begin
			a = lo[i];
			b = hi[i];
			if (b < a) begin
				a = hi[i];
				b = lo[i];
			end
			span = b - a;
			if (pick == 9)
				f[i] = $urandom_range(SAMPLE_MAX);
			else if (on[i])
				f[i] = ($urandom_range(7) == 0) ? SAMPLE_W'(SAMPLE_MAX)
					: SAMPLE_W'(b - int'($urandom_range(span / 3)));
			else
				f[i] = ($urandom_range(7) == 0) ? '0
					: SAMPLE_W'(a + int'($urandom_range(span / 4)));
		end
		return f;
	endfunction

	task automatic send_frame(action_e act, frame_t s);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action   <= act;
		sample_0 <= s[0];
		sample_1 <= s[1];
		sample_2 <= s[2];
		sample_3 <= s[3];
		sample_4 <= s[4];
		sample_5 <= s[5];
		// hold the request until taken
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (act != ACT_UNUSED)
			item_total++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic set_levels(int noise, int level);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= REG_NOISE_FLOOR;
		cfg_data  <= noise[7:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_index <= REG_LINE_LEVEL;
		cfg_data  <= level[7:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_episode();
		frame_t lo;
		frame_t hi;
		int a;
		int b;
		if ($urandom_range(2) != 0)
			send_frame(ACT_CLEAR, random_frame());
		for (int i = 0; i < SENSOR_COUNT; i++) begin
			case ($urandom_range(4))
				0: begin
					a = 0;
					b = SAMPLE_MAX;
				end
				1: begin
					a = $urandom_range(SAMPLE_MAX - 25);
					b = a + $urandom_range(25);
				end
				default: begin
					a = $urandom_range(SAMPLE_MAX);
					b = $urandom_range(SAMPLE_MAX);
					if (b < a) begin
						b = a;
						a = $urandom_range(b);
					end
				end
			endcase
			lo[i] = a;
			hi[i] = b;
		end
		// now and then measure with no calibrate frames in this episode
		if ($urandom_range(9) != 0) begin
			send_frame(ACT_CALIBRATE, lo);
			send_frame(ACT_CALIBRATE, hi);
			if ($urandom_range(3) == 0)
				send_frame(ACT_CALIBRATE, random_frame());
		end
		repeat ($urandom_range(4, 14)) begin
			if ($urandom_range(19) == 0)
				send_frame(ACT_UNUSED, random_frame());
			send_frame(ACT_MEASURE, line_frame(lo, hi));
		end
	endtask

	initial begin
		int target;
		bit pressured;
		pressured = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed
		send_frame(ACT_MEASURE, uniform(0));
		send_frame(ACT_UNUSED, uniform(SAMPLE_MAX));
		send_frame(ACT_CALIBRATE, uniform(0));
		send_frame(ACT_CALIBRATE, uniform(SAMPLE_MAX));
		send_frame(ACT_MEASURE, uniform(SAMPLE_MAX));
		send_frame(ACT_MEASURE, make_frame(SAMPLE_MAX, 0, 0, 0, 0, 0));
		send_frame(ACT_MEASURE, uniform(0));
		send_frame(ACT_MEASURE, make_frame(0, 0, 0, 0, 0, SAMPLE_MAX));
		send_frame(ACT_MEASURE, uniform(0));
		send_frame(ACT_MEASURE, make_frame(0, 0, SAMPLE_MAX, SAMPLE_MAX, 0, 0));
		send_frame(ACT_MEASURE, make_frame(0, SAMPLE_MAX, 0, 0, 2047, 0));
		send_frame(ACT_MEASURE, make_frame(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 0, 0, 0));
		send_frame(ACT_MEASURE, make_frame(200, 300, 409, 410, 1000, 4000));
		send_frame(ACT_CLEAR, uniform(SAMPLE_MAX));
		send_frame(ACT_MEASURE, uniform(2048));
		send_frame(ACT_CALIBRATE, uniform(1000));
		send_frame(ACT_CALIBRATE, uniform(1005));
		send_frame(ACT_MEASURE, uniform(1003));
		send_frame(ACT_CALIBRATE, uniform(1019));
		send_frame(ACT_MEASURE, make_frame(SAMPLE_MAX, 0, 1019, 1010, 1001, 1000));
		send_frame(ACT_MEASURE, make_frame(1019, 1000, 1000, 1000, 1000, 1000));
		set_levels(0, 0);
		send_frame(ACT_MEASURE, make_frame(1001, 1000, 1000, 1000, 1000, 1000));
		send_frame(ACT_MEASURE, uniform(1000));
		set_levels(255, 255);
		send_frame(ACT_MEASURE, uniform(1019));
		set_levels(0, 255);
		send_frame(ACT_MEASURE, uniform(1019));

		// random phases
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: set_levels(10, 25);
				1: set_levels($urandom_range(20), $urandom_range(80));
				2: set_levels(0, 50);
				default: set_levels(5, $urandom_range(10, 120));
			endcase
			case (p)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 78; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 78; end
				default: begin idle_pct = 15; stall_pct = 15; end
			endcase
			target = item_total + RANDOM_ITEMS / 4;
			while (item_total < target) begin
				if (p == 0 && !pressured && item_total > target - 150) begin
					hold_len = HOLD_CYCLES;
					run_episode();
					wait_drained();
					pressured = 1'b1;
				end else begin
					run_episode();
				end
			end
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: line_sensor_position_estimator.f
+incdir+rtl/core
rtl/core/ls_pkg.sv
rtl/core/ls_cal.sv
rtl/core/ls_div.sv
rtl/core/line_sensor_position_estimator.sv
tb/lspe_tb_pkg.sv
tb/line_estimate_checker.sv
tb/tb.sv
